>>> rtl/fspc_pkg.sv
// shared constants, codes and types of the frustum sphere cull block
package fspc_pkg;

    localparam int COORD_WIDTH_DEF    = 16;
    localparam int AXIS_FRAC_BITS_DEF = 14;

    // fraction bits of the q4.12 scale registers
    localparam int Q412_FRAC = 12;

    // near, far, tangent, ratio and widening factors are 16-bit fields
    localparam int HALF_W = 16;
    localparam int SCALE_PROD_W = 2 * HALF_W;

    // queue between projection and classification
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CAMERA_POSITION  = 3'd0,
        CFG_VIEW_AXIS_BACK   = 3'd1,
        CFG_VIEW_AXIS_RIGHT  = 3'd2,
        CFG_VIEW_AXIS_UP     = 3'd3,
        CFG_NEAR_FAR         = 3'd4,
        CFG_TAN_HALF_FOV     = 3'd5,
        CFG_ASPECT_RATIO     = 3'd6,
        CFG_SPHERE_WIDEN     = 3'd7
    } fspc_cfg_index_t;

    typedef enum logic [1:0] {
        VERDICT_OUTSIDE   = 2'd0,
        VERDICT_INSIDE    = 2'd1,
        VERDICT_INTERSECT = 2'd2
    } fspc_verdict_t;

    // depth and side scale values used by the classifier
    typedef struct packed {
        logic [HALF_W-1:0]       near_dist;
        logic [HALF_W-1:0]       far_dist;
        logic [HALF_W-1:0]       tan_fov;
        logic [SCALE_PROD_W-1:0] tan_ratio;
        logic [HALF_W-1:0]       widen_h;
        logic [HALF_W-1:0]       widen_v;
    } fspc_scale_t;

    // queue status seen by both sides
    typedef struct packed {
        logic              empty;
        logic [QCNT_W-1:0] count;
    } fspc_q_stat_t;

endpackage

>>> rtl/fspc_front.sv
// front end: request intake, eye offset and projection onto the camera axes
module fspc_front #(
    parameter int COORD_WIDTH    = fspc_pkg::COORD_WIDTH_DEF,
    parameter int AXIS_FRAC_BITS = fspc_pkg::AXIS_FRAC_BITS_DEF,
    localparam int AW      = AXIS_FRAC_BITS + 2,
    localparam int CAM_W   = (3 * COORD_WIDTH > 64) ? 64 : 3 * COORD_WIDTH,
    localparam int AX_W    = (3 * AW > 64) ? 64 : 3 * AW,
    localparam int DW      = COORD_WIDTH + AW + 3,
    localparam int ENTRY_W = 3 * DW + COORD_WIDTH - 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] point_x,
    input  logic signed [COORD_WIDTH-1:0] point_y,
    input  logic signed [COORD_WIDTH-1:0] point_z,
    input  logic [COORD_WIDTH-2:0]        sphere_radius,
    input  logic [CAM_W-1:0]              cam_pos,
    input  logic [AX_W-1:0]               axis_back,
    input  logic [AX_W-1:0]               axis_right,
    input  logic [AX_W-1:0]               axis_up,
    input  fspc_pkg::fspc_q_stat_t        q_stat,
    output logic                          push,
    output logic [ENTRY_W-1:0]            push_data
);
    import fspc_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int VW = CW + 1;
    localparam int PW = VW + AW;
    localparam int OCC_W = QCNT_W + 1;

    logic [3*CW-1:0] cam_full;
    logic [3*AW-1:0] back_full;
    logic [3*AW-1:0] right_full;
    logic [3*AW-1:0] up_full;
    logic signed [CW-1:0] cam_c [3];
    logic signed [AW-1:0] back_c [3];
    logic signed [AW-1:0] right_c [3];
    logic signed [AW-1:0] up_c [3];
    logic signed [CW-1:0] pt [3];

    logic                 accept;
    logic [OCC_W-1:0]     occupancy;
    logic                 a_valid_reg;
    logic                 b_valid_reg;
    logic signed [VW-1:0] v_next [3];
    logic signed [VW-1:0] v_reg [3];
    logic [CW-2:0]        rad_a_reg;
    logic signed [PW-1:0] prod_bk_next [3];
    logic signed [PW-1:0] prod_rt_next [3];
    logic signed [PW-1:0] prod_up_next [3];
    logic signed [PW-1:0] prod_bk_reg [3];
    logic signed [PW-1:0] prod_rt_reg [3];
    logic signed [PW-1:0] prod_up_reg [3];
    logic [CW-2:0]        rad_b_reg;
    logic signed [DW-1:0] dot_bk;
    logic signed [DW-1:0] dot_rt;
    logic signed [DW-1:0] dot_up;

    // components lying above bit 63 of a register read as zero
    always_comb
    begin
        cam_full   = '0;
        back_full  = '0;
        right_full = '0;
        up_full    = '0;
        cam_full[CAM_W-1:0]  = cam_pos;
        back_full[AX_W-1:0]  = axis_back;
        right_full[AX_W-1:0] = axis_right;
        up_full[AX_W-1:0]    = axis_up;
        pt[0] = point_x;
        pt[1] = point_y;
        pt[2] = point_z;
        for (int i = 0; i < 3; i++)
        begin
            cam_c[i]   = cam_full[i*CW +: CW];
            back_c[i]  = back_full[i*AW +: AW];
            right_c[i] = right_full[i*AW +: AW];
            up_c[i]    = up_full[i*AW +: AW];
            v_next[i]  = VW'(pt[i]) - VW'(cam_c[i]);
        end
    end

    // credit check: every request in flight has a queue slot waiting
    assign occupancy = OCC_W'(q_stat.count) + OCC_W'(a_valid_reg) + OCC_W'(b_valid_reg);
    assign busy      = (occupancy >= OCC_W'(QUEUE_DEPTH));
    assign accept    = start && !busy;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod_bk_next[i] = v_reg[i] * back_c[i];
            prod_rt_next[i] = v_reg[i] * right_c[i];
            prod_up_next[i] = v_reg[i] * up_c[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= accept;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            v_reg     <= v_next;
            rad_a_reg <= sphere_radius;
        end
        if (a_valid_reg)
        begin
            prod_bk_reg <= prod_bk_next;
            prod_rt_reg <= prod_rt_next;
            prod_up_reg <= prod_up_next;
            rad_b_reg   <= rad_a_reg;
        end
    end

    assign dot_bk = DW'(prod_bk_reg[0]) + DW'(prod_bk_reg[1]) + DW'(prod_bk_reg[2]);
    assign dot_rt = DW'(prod_rt_reg[0]) + DW'(prod_rt_reg[1]) + DW'(prod_rt_reg[2]);
    assign dot_up = DW'(prod_up_reg[0]) + DW'(prod_up_reg[1]) + DW'(prod_up_reg[2]);

    assign push      = b_valid_reg;
    assign push_data = {dot_bk, dot_rt, dot_up, rad_b_reg};

endmodule

>>> rtl/fspc_queue.sv
// short fifo between the projection front end and the classifier
module fspc_queue #(
    parameter int WIDTH = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic [WIDTH-1:0]       wdata,
    input  logic                   pop,
    output logic [WIDTH-1:0]       rdata,
    output fspc_pkg::fspc_q_stat_t stat
);
    import fspc_pkg::*;

    logic [WIDTH-1:0]  mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata      = mem_reg[rd_ptr_reg];
    assign stat.count = count_reg;
    assign stat.empty = (count_reg == '0);

endmodule

>>> rtl/fspc_back.sv
// classifier: depth and side bounds, comparisons and verdict
module fspc_back #(
    parameter int COORD_WIDTH    = fspc_pkg::COORD_WIDTH_DEF,
    parameter int AXIS_FRAC_BITS = fspc_pkg::AXIS_FRAC_BITS_DEF,
    localparam int AW      = AXIS_FRAC_BITS + 2,
    localparam int DW      = COORD_WIDTH + AW + 3,
    localparam int ENTRY_W = 3 * DW + COORD_WIDTH - 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  fspc_pkg::fspc_scale_t  scale,
    input  logic [ENTRY_W-1:0]     q_rdata,
    input  fspc_pkg::fspc_q_stat_t q_stat,
    output logic                   pop,
    output logic                   done,
    output logic [1:0]             verdict
);
    import fspc_pkg::*;

    localparam int CW   = COORD_WIDTH;
    localparam int RW   = CW - 1;
    localparam int ZDW  = DW + 1;
    localparam int ZY_W = ZDW + HALF_W + 1;
    localparam int ZX_W = ZDW + SCALE_PROD_W + 1;
    localparam int PDW  = HALF_W + RW;
    localparam int XW   = ZX_W + 2;
    localparam int YW   = ZY_W + 2;
    localparam int ZW   = ((ZDW > AXIS_FRAC_BITS + HALF_W + 1) ?
                           ZDW : AXIS_FRAC_BITS + HALF_W + 1) + 2;

    logic signed [DW-1:0] q_bk;
    logic signed [DW-1:0] q_rt;
    logic signed [DW-1:0] q_up;
    logic [RW-1:0]        q_rad;

    logic c_valid_reg;
    logic d_valid_reg;
    logic e_valid_reg;
    logic done_reg;

    // stage c: depth sign flip
    logic signed [ZDW-1:0] az_c_next;
    logic signed [ZDW-1:0] az_c_reg;
    logic signed [DW-1:0]  ax_c_reg;
    logic signed [DW-1:0]  ay_c_reg;
    logic [RW-1:0]         rad_c_reg;

    // stage d: depth scaled by tangent and ratio, radius by the secants
    logic signed [ZX_W-1:0] zz1_next;
    logic signed [ZY_W-1:0] zz2_next;
    logic [PDW-1:0]         pd1_next;
    logic [PDW-1:0]         pd2_next;
    logic signed [ZX_W-1:0] zz1_reg;
    logic signed [ZY_W-1:0] zz2_reg;
    logic [PDW-1:0]         pd1_reg;
    logic [PDW-1:0]         pd2_reg;
    logic signed [ZDW-1:0]  az_d_reg;
    logic signed [DW-1:0]   ax_d_reg;
    logic signed [DW-1:0]   ay_d_reg;
    logic [RW-1:0]          rad_d_reg;

    // stage e: bounds at a common fraction per axis
    logic signed [XW-1:0] hx_next;
    logic signed [XW-1:0] lx_next;
    logic signed [XW-1:0] ax24_next;
    logic signed [YW-1:0] hy_next;
    logic signed [YW-1:0] ly_next;
    logic signed [YW-1:0] ay12_next;
    logic signed [ZW-1:0] rw_e;
    logic signed [ZW-1:0] nearw_e;
    logic signed [ZW-1:0] farw_e;
    logic signed [ZW-1:0] far_hi_next;
    logic signed [ZW-1:0] far_in_next;
    logic signed [ZW-1:0] near_lo_next;
    logic signed [ZW-1:0] near_in_next;
    logic signed [ZW-1:0] az_e_next;

    logic signed [XW-1:0] hx_reg;
    logic signed [XW-1:0] lx_reg;
    logic signed [XW-1:0] ax24_reg;
    logic signed [YW-1:0] hy_reg;
    logic signed [YW-1:0] ly_reg;
    logic signed [YW-1:0] ay12_reg;
    logic signed [ZW-1:0] far_hi_reg;
    logic signed [ZW-1:0] far_in_reg;
    logic signed [ZW-1:0] near_lo_reg;
    logic signed [ZW-1:0] near_in_reg;
    logic signed [ZW-1:0] az_e_reg;

    // stage f: compares
    logic signed [XW-1:0] sum_hx;
    logic signed [XW-1:0] sum_lx;
    logic signed [YW-1:0] sum_hy;
    logic signed [YW-1:0] sum_ly;
    logic                 out_fail;
    logic                 in_fail;
    fspc_verdict_t        verdict_next;
    fspc_verdict_t        verdict_reg;

    assign q_bk  = q_rdata[ENTRY_W-1 -: DW];
    assign q_rt  = q_rdata[2*DW+RW-1 -: DW];
    assign q_up  = q_rdata[DW+RW-1 -: DW];
    assign q_rad = q_rdata[RW-1:0];

    // the back end never stalls
    assign pop = !q_stat.empty;

    assign az_c_next = -ZDW'(q_bk);

    assign zz2_next = az_c_reg * $signed({1'b0, scale.tan_fov});
    assign zz1_next = az_c_reg * $signed({1'b0, scale.tan_ratio});
    assign pd1_next = PDW'(scale.widen_h) * PDW'(rad_c_reg);
    assign pd2_next = PDW'(scale.widen_v) * PDW'(rad_c_reg);

    always_comb
    begin
        hx_next   = XW'(zz1_reg) + ($signed(XW'(pd1_reg)) <<< (AXIS_FRAC_BITS + Q412_FRAC));
        lx_next   = XW'(zz1_reg) - ($signed(XW'(pd1_reg)) <<< (AXIS_FRAC_BITS + Q412_FRAC));
        ax24_next = XW'(ax_d_reg) <<< (2 * Q412_FRAC);
        hy_next   = YW'(zz2_reg) + ($signed(YW'(pd2_reg)) <<< AXIS_FRAC_BITS);
        ly_next   = YW'(zz2_reg) - ($signed(YW'(pd2_reg)) <<< AXIS_FRAC_BITS);
        ay12_next = YW'(ay_d_reg) <<< Q412_FRAC;
        rw_e      = $signed(ZW'(rad_d_reg)) <<< AXIS_FRAC_BITS;
        nearw_e   = $signed(ZW'(scale.near_dist)) <<< AXIS_FRAC_BITS;
        farw_e    = $signed(ZW'(scale.far_dist)) <<< AXIS_FRAC_BITS;
        far_hi_next  = farw_e + rw_e;
        far_in_next  = farw_e - rw_e;
        near_lo_next = nearw_e - rw_e;
        near_in_next = nearw_e + rw_e;
        az_e_next    = ZW'(az_d_reg);
    end

    // x < -b is tested as x + b < 0
    always_comb
    begin
        sum_hx = ax24_reg + hx_reg;
        sum_lx = ax24_reg + lx_reg;
        sum_hy = ay12_reg + hy_reg;
        sum_ly = ay12_reg + ly_reg;
        out_fail = (az_e_reg > far_hi_reg) || (az_e_reg < near_lo_reg)
                || (ax24_reg > hx_reg) || sum_hx[XW-1]
                || (ay12_reg > hy_reg) || sum_hy[YW-1];
        in_fail  = (az_e_reg > far_in_reg) || (az_e_reg < near_in_reg)
                || (ax24_reg > lx_reg) || sum_lx[XW-1]
                || (ay12_reg > ly_reg) || sum_ly[YW-1];
        if (out_fail)
        begin
            verdict_next = VERDICT_OUTSIDE;
        end
        else if (in_fail)
        begin
            verdict_next = VERDICT_INTERSECT;
        end
        else
        begin
            verdict_next = VERDICT_INSIDE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            c_valid_reg <= pop;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
            done_reg    <= e_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            az_c_reg  <= az_c_next;
            ax_c_reg  <= q_rt;
            ay_c_reg  <= q_up;
            rad_c_reg <= q_rad;
        end
        if (c_valid_reg)
        begin
            zz1_reg   <= zz1_next;
            zz2_reg   <= zz2_next;
            pd1_reg   <= pd1_next;
            pd2_reg   <= pd2_next;
            az_d_reg  <= az_c_reg;
            ax_d_reg  <= ax_c_reg;
            ay_d_reg  <= ay_c_reg;
            rad_d_reg <= rad_c_reg;
        end
        if (d_valid_reg)
        begin
            hx_reg      <= hx_next;
            lx_reg      <= lx_next;
            ax24_reg    <= ax24_next;
            hy_reg      <= hy_next;
            ly_reg      <= ly_next;
            ay12_reg    <= ay12_next;
            far_hi_reg  <= far_hi_next;
            far_in_reg  <= far_in_next;
            near_lo_reg <= near_lo_next;
            near_in_reg <= near_in_next;
            az_e_reg    <= az_e_next;
        end
        if (e_valid_reg)
        begin
            verdict_reg <= verdict_next;
        end
    end

    assign done    = done_reg;
    assign verdict = verdict_reg;

endmodule

>>> rtl/frustum_sphere_point_cull.sv
// top level of the frustum sphere and point cull block
//
// Classifies a sphere (center point_x/y/z, radius sphere_radius; radius zero
// is the plain point test) against a view frustum held in configuration
// registers, and reports outside, inside or intersect on verdict. A request
// is taken at a clock edge where start is high and busy is low; one request
// can be taken every clock. Its verdict appears on the ports for exactly one
// cycle with done high, in request order. The receiver cannot stall: done and
// verdict must be sampled on that cycle. busy only rises when the four-entry
// queue between the front end and the classifier has no free credit left for
// the requests still in the two front stages, which does not happen in steady
// flow because the classifier drains one entry every clock. Configuration
// registers are written through cfg_valid/cfg_index/cfg_data (cfg_ready is
// always high) and take effect on the next clock; the user must write them
// only while no request is in flight, which the block does not enforce.
module frustum_sphere_point_cull #(
    parameter int COORD_WIDTH    = fspc_pkg::COORD_WIDTH_DEF,
    parameter int AXIS_FRAC_BITS = fspc_pkg::AXIS_FRAC_BITS_DEF,
    localparam int AW    = AXIS_FRAC_BITS + 2,
    localparam int CAM_W = (3 * COORD_WIDTH > 64) ? 64 : 3 * COORD_WIDTH,
    localparam int AX_W  = (3 * AW > 64) ? 64 : 3 * AW,
    localparam int CFG_W0 = (CAM_W > AX_W) ? CAM_W : AX_W,
    localparam int CFG_W  = (CFG_W0 > 2 * fspc_pkg::HALF_W) ? CFG_W0 : 2 * fspc_pkg::HALF_W
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [COORD_WIDTH-1:0]       point_x,
    input  logic signed [COORD_WIDTH-1:0]       point_y,
    input  logic signed [COORD_WIDTH-1:0]       point_z,
    input  logic [COORD_WIDTH-2:0]              sphere_radius,
    output logic                                done,
    output logic [1:0]                          verdict,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fspc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]                    cfg_data
);
    import fspc_pkg::*;

    localparam int DW      = COORD_WIDTH + AW + 3;
    localparam int ENTRY_W = 3 * DW + COORD_WIDTH - 1;

    // configuration registers
    logic [CAM_W-1:0]        cam_reg;
    logic [CAM_W-1:0]        cam_next;
    logic [AX_W-1:0]         back_reg;
    logic [AX_W-1:0]         back_next;
    logic [AX_W-1:0]         right_reg;
    logic [AX_W-1:0]         right_next;
    logic [AX_W-1:0]         up_reg;
    logic [AX_W-1:0]         up_next;
    logic [2*HALF_W-1:0]     near_far_reg;
    logic [2*HALF_W-1:0]     near_far_next;
    logic [HALF_W-1:0]       tan_reg;
    logic [HALF_W-1:0]       tan_next;
    logic [HALF_W-1:0]       ratio_reg;
    logic [HALF_W-1:0]       ratio_next;
    logic [2*HALF_W-1:0]     widen_reg;
    logic [2*HALF_W-1:0]     widen_next;
    // tangent times ratio, kept current with every write of either factor
    logic [SCALE_PROD_W-1:0] tan_ratio_reg;
    logic [SCALE_PROD_W-1:0] tan_ratio_next;

    fspc_scale_t  scale;
    fspc_q_stat_t q_stat;
    logic         push;
    logic         pop;
    logic [ENTRY_W-1:0] push_data;
    logic [ENTRY_W-1:0] q_rdata;
    logic         cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb
    begin
        cam_next       = cam_reg;
        back_next      = back_reg;
        right_next     = right_reg;
        up_next        = up_reg;
        near_far_next  = near_far_reg;
        tan_next       = tan_reg;
        ratio_next     = ratio_reg;
        widen_next     = widen_reg;
        tan_ratio_next = tan_ratio_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_CAMERA_POSITION: cam_next      = cfg_data[CAM_W-1:0];
                CFG_VIEW_AXIS_BACK:  back_next     = cfg_data[AX_W-1:0];
                CFG_VIEW_AXIS_RIGHT: right_next    = cfg_data[AX_W-1:0];
                CFG_VIEW_AXIS_UP:    up_next       = cfg_data[AX_W-1:0];
                CFG_NEAR_FAR:        near_far_next = cfg_data[2*HALF_W-1:0];
                CFG_TAN_HALF_FOV:
                begin
                    tan_next       = cfg_data[HALF_W-1:0];
                    tan_ratio_next = SCALE_PROD_W'(cfg_data[HALF_W-1:0])
                                   * SCALE_PROD_W'(ratio_reg);
                end
                CFG_ASPECT_RATIO:
                begin
                    ratio_next     = cfg_data[HALF_W-1:0];
                    tan_ratio_next = SCALE_PROD_W'(tan_reg)
                                   * SCALE_PROD_W'(cfg_data[HALF_W-1:0]);
                end
                CFG_SPHERE_WIDEN:    widen_next    = cfg_data[2*HALF_W-1:0];
                default:
                begin
                    cam_next = cam_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_reg       <= '0;
            back_reg      <= '0;
            right_reg     <= '0;
            up_reg        <= '0;
            near_far_reg  <= '0;
            tan_reg       <= '0;
            ratio_reg     <= '0;
            widen_reg     <= '0;
            tan_ratio_reg <= '0;
        end
        else
        begin
            cam_reg       <= cam_next;
            back_reg      <= back_next;
            right_reg     <= right_next;
            up_reg        <= up_next;
            near_far_reg  <= near_far_next;
            tan_reg       <= tan_next;
            ratio_reg     <= ratio_next;
            widen_reg     <= widen_next;
            tan_ratio_reg <= tan_ratio_next;
        end
    end

    // near in the low half, far in the high half; same split for the secants
    assign scale.near_dist = near_far_reg[HALF_W-1:0];
    assign scale.far_dist  = near_far_reg[2*HALF_W-1:HALF_W];
    assign scale.tan_fov   = tan_reg;
    assign scale.tan_ratio = tan_ratio_reg;
    assign scale.widen_h   = widen_reg[HALF_W-1:0];
    assign scale.widen_v   = widen_reg[2*HALF_W-1:HALF_W];

    // front end: eye offset, then the three axis projections
    fspc_front #(
        .COORD_WIDTH    (COORD_WIDTH),
        .AXIS_FRAC_BITS (AXIS_FRAC_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .point_x       (point_x),
        .point_y       (point_y),
        .point_z       (point_z),
        .sphere_radius (sphere_radius),
        .cam_pos       (cam_reg),
        .axis_back     (back_reg),
        .axis_right    (right_reg),
        .axis_up       (up_reg),
        .q_stat        (q_stat),
        .push          (push),
        .push_data     (push_data)
    );

    // projected requests wait here for the classifier
    fspc_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (push_data),
        .pop   (pop),
        .rdata (q_rdata),
        .stat  (q_stat)
    );

    // classifier: scaled bounds, compares and the verdict strobe
    fspc_back #(
        .COORD_WIDTH    (COORD_WIDTH),
        .AXIS_FRAC_BITS (AXIS_FRAC_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .scale   (scale),
        .q_rdata (q_rdata),
        .q_stat  (q_stat),
        .pop     (pop),
        .done    (done),
        .verdict (verdict)
    );

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench of the frustum sphere and point cull block
module testbench;
    import fspc_pkg::*;

    localparam int CFG_DATA_W     = 48;
    localparam int AXF            = AXIS_FRAC_BITS_DEF;
    localparam int WATCHDOG_LIMIT = 4000;
    // quiet clocks at the end, after the last owed verdict has come back
    localparam int TAIL_CYCLES    = 12;
    localparam int MAX_GAP        = 200;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic signed [15:0]       point_x;
    logic signed [15:0]       point_y;
    logic signed [15:0]       point_z;
    logic [14:0]              sphere_radius;
    logic                     done;
    logic [1:0]               verdict;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_INDEX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;

    // shadow copy of the view registers, updated on each accepted write
    logic [47:0]              cam_pos;
    logic [47:0]              axis_back;
    logic [47:0]              axis_right;
    logic [47:0]              axis_up;
    logic [31:0]              near_far;
    logic [31:0]              widen;
    logic [15:0]              tan_fov;
    logic [15:0]              aspect;

    // verdicts still owed by the block, oldest first
    fspc_verdict_t            verdicts_due[$];
    int                       error_count;
    int                       idle_pct;
    int                       quiet_cycles;

    frustum_sphere_point_cull i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .point_x       (point_x),
        .point_y       (point_y),
        .point_z       (point_z),
        .sphere_radius (sphere_radius),
        .done          (done),
        .verdict       (verdict),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // 20 ns clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // one signed q1.14 / q11.4 component out of a packed x,y,z register
    function automatic logic signed [15:0] component(input logic [47:0] xyz, input int idx);
        return xyz[16*idx +: 16];
    endfunction

    function automatic logic [47:0] pack3(input longint x, input longint y, input longint z);
        logic [15:0] px;
        logic [15:0] py;
        logic [15:0] pz;
        px = x[15:0];
        py = y[15:0];
        pz = z[15:0];
        return {pz, py, px};
    endfunction

    // exact classification of one sphere against the shadow view
    // everything is widened to 128 bits signed so no product can wrap
    function automatic fspc_verdict_t classify_sphere(input logic signed [15:0] px,
                                                      input logic signed [15:0] py,
                                                      input logic signed [15:0] pz,
                                                      input logic [14:0] rad);
        logic signed [15:0]  cx;
        logic signed [15:0]  cy;
        logic signed [15:0]  cz;
        logic signed [127:0] vx;
        logic signed [127:0] vy;
        logic signed [127:0] vz;
        logic signed [127:0] depth;
        logic signed [127:0] side;
        logic signed [127:0] height;
        logic signed [127:0] radw;
        logic signed [127:0] rw;
        logic signed [127:0] nearw;
        logic signed [127:0] farw;
        logic signed [127:0] tanw;
        logic signed [127:0] ratw;
        logic signed [127:0] fhw;
        logic signed [127:0] fvw;
        logic signed [127:0] zz1;
        logic signed [127:0] zz2;
        logic signed [127:0] d1;
        logic signed [127:0] d2;
        logic signed [127:0] side24;
        logic signed [127:0] height12;
        fspc_verdict_t       result;

        cx = cam_pos[15:0];
        cy = cam_pos[31:16];
        cz = cam_pos[47:32];
        vx = px - cx;
        vy = py - cy;
        vz = pz - cz;

        // depth runs against the back axis
        depth  = -(vx * component(axis_back, 0) + vy * component(axis_back, 1)
                   + vz * component(axis_back, 2));
        side   = vx * component(axis_right, 0) + vy * component(axis_right, 1)
                 + vz * component(axis_right, 2);
        height = vx * component(axis_up, 0) + vy * component(axis_up, 1)
                 + vz * component(axis_up, 2);

        // bring everything to the dot product fraction first
        radw  = rad;
        rw    = radw <<< AXF;
        nearw = near_far[15:0];
        nearw = nearw <<< AXF;
        farw  = near_far[31:16];
        farw  = farw <<< AXF;
        tanw  = tan_fov;
        ratw  = aspect;
        fhw   = widen[15:0];
        fvw   = widen[31:16];

        zz2      = depth * tanw;
        zz1      = zz2 * ratw;
        d2       = (fvw * radw) <<< AXF;
        d1       = (fhw * radw) <<< (AXF + Q412_FRAC);
        height12 = height <<< Q412_FRAC;
        side24   = side <<< (2 * Q412_FRAC);

        if (farw + rw < depth || depth < nearw - rw)
            result = VERDICT_OUTSIDE;
        else if (zz1 + d1 < side24 || side24 < -zz1 - d1)
            result = VERDICT_OUTSIDE;
        else if (zz2 + d2 < height12 || height12 < -zz2 - d2)
            result = VERDICT_OUTSIDE;
        else
        begin
            result = VERDICT_INSIDE;
            // shrunk bounds decide between fully inside and straddling
            if (farw - rw < depth || depth < nearw + rw
                || zz2 - d2 < height12 || height12 < -zz2 + d2
                || zz1 - d1 < side24 || side24 < -zz1 + d1)
                result = VERDICT_INTERSECT;
        end
        return result;
    endfunction

    // geometric run of idle cycles, mean fraction set by idle_pct
    function automatic int idle_gap();
        int n;
        n = 0;
        while (n < MAX_GAP && $urandom_range(99) < idle_pct)
            n++;
        return n;
    endfunction

    function automatic longint rand_signed(input longint lim);
        longint span;
        span = (lim > 60000) ? 60000 : ((lim < 0) ? 0 : lim);
        return longint'($urandom_range(0, 32'(2 * span))) - span;
    endfunction

    // single register write, entered and left at a falling edge
    task automatic write_reg(input fspc_cfg_index_t idx, input logic [47:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_CAMERA_POSITION: cam_pos    = data;
            CFG_VIEW_AXIS_BACK:  axis_back  = data;
            CFG_VIEW_AXIS_RIGHT: axis_right = data;
            CFG_VIEW_AXIS_UP:    axis_up    = data;
            CFG_NEAR_FAR:        near_far   = data[31:0];
            CFG_TAN_HALF_FOV:    tan_fov    = data[15:0];
            CFG_ASPECT_RATIO:    aspect     = data[15:0];
            CFG_SPHERE_WIDEN:    widen      = data[31:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic load_view(input logic [47:0] cam, input logic [47:0] back,
                             input logic [47:0] right, input logic [47:0] up,
                             input logic [31:0] nf, input logic [15:0] tanv,
                             input logic [15:0] ratio, input logic [31:0] wf);
        write_reg(CFG_CAMERA_POSITION, cam);
        write_reg(CFG_VIEW_AXIS_BACK, back);
        write_reg(CFG_VIEW_AXIS_RIGHT, right);
        write_reg(CFG_VIEW_AXIS_UP, up);
        write_reg(CFG_NEAR_FAR, {16'd0, nf});
        write_reg(CFG_TAN_HALF_FOV, {32'd0, tanv});
        write_reg(CFG_ASPECT_RATIO, {32'd0, ratio});
        write_reg(CFG_SPHERE_WIDEN, {16'd0, wf});
    endtask

    // eye at (10,20,30), looking down -z, near 1, far 100, 4:3, 90 degree fov
    task automatic load_nominal_view();
        load_view(pack3(160, 320, 480), pack3(0, 0, 16384), pack3(16384, 0, 0),
                  pack3(0, 16384, 0), {16'd1600, 16'd16}, 16'd4096, 16'd5461,
                  {16'd5793, 16'd5793});
    endtask

    // one request; entered at a falling edge, start stays high when no gap follows
    task automatic send_query(input logic signed [15:0] x, input logic signed [15:0] y,
                              input logic signed [15:0] z, input logic [14:0] rad);
        int gap;
        start         <= 1'b1;
        point_x       <= x;
        point_y       <= y;
        point_z       <= z;
        sphere_radius <= rad;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        verdicts_due.push_back(classify_sphere(x, y, z, rad));
        @(negedge clk);
        gap = idle_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // hold off new requests until every owed verdict has come back
    task automatic wait_drained();
        start <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // sphere placed in the camera frame around the current frustum
    task automatic send_framed();
        longint rad;
        longint d;
        longint s;
        longint h;
        longint wb;
        longint hb;
        longint tanv;
        longint ratv;
        longint fhv;
        longint fvv;
        longint farv;
        longint off;
        logic signed [15:0] p[3];
        int sel;

        sel = $urandom_range(9);
        if (sel < 3)
            rad = 0;
        else if (sel < 8)
            rad = longint'($urandom_range(0, 96));
        else if (sel == 8)
            rad = longint'($urandom_range(0, 1600));
        else
            rad = longint'($urandom_range(0, 32767));

        tanv = tan_fov;
        ratv = aspect;
        fhv  = widen[15:0];
        fvv  = widen[31:16];
        farv = near_far[31:16];

        // depth from a little behind the eye to a little past far
        d  = longint'($urandom_range(0, 32'(farv + 2 * rad + 64))) - rad - 32;
        wb = (d * tanv * ratv) >>> 24;
        hb = (d * tanv) >>> 12;
        if (wb < 0)
            wb = -wb;
        if (hb < 0)
            hb = -hb;
        s = rand_signed((wb + ((fhv * rad) >>> 12) + 16) * 5 / 4);
        h = rand_signed((hb + ((fvv * rad) >>> 12) + 16) * 5 / 4);

        for (int i = 0; i < 3; i++)
        begin
            off = (s * longint'(component(axis_right, i)) + h * longint'(component(axis_up, i))
                   - d * longint'(component(axis_back, i))) >>> AXF;
            off = off + longint'(component(cam_pos, i));
            p[i] = off[15:0];
        end
        send_query(p[0], p[1], p[2], rad[14:0]);
    endtask

    // mostly well-placed spheres, the rest arbitrary bit patterns
    task automatic send_random_item();
        if ($urandom_range(99) < 80)
            send_framed();
        else
            send_query(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                       16'($urandom_range(65535)), 15'($urandom_range(32767)));
    endtask

    // random orthonormal view rotated about y, now and then raw axis bits
    task automatic load_random_view();
        int cos_tab[5];
        int sin_tab[5];
        int a;
        int c;
        int s;
        int u;
        logic [15:0] tanv;
        logic [15:0] ratio;
        int nearv;
        int farv;
        logic [47:0] back;
        logic [47:0] right;
        logic [47:0] up;

        cos_tab = '{16384, 14189, 11585, 8192, 0};
        sin_tab = '{0, 8192, 11585, 14189, 16384};
        a = $urandom_range(4);
        c = $urandom_range(1) ? cos_tab[a] : -cos_tab[a];
        s = $urandom_range(1) ? sin_tab[a] : -sin_tab[a];
        u = $urandom_range(1) ? 16384 : -16384;
        back  = pack3(s, 0, c);
        right = pack3(c, 0, -s);
        up    = pack3(0, u, 0);
        if ($urandom_range(7) == 0)
        begin
            back  = {16'($urandom_range(65535)), 32'($urandom)};
            right = {16'($urandom_range(65535)), 32'($urandom)};
            up    = {16'($urandom_range(65535)), 32'($urandom)};
        end
        nearv = $urandom_range(0, 80);
        farv  = nearv + $urandom_range(16, 4000);
        tanv  = ($urandom_range(5) == 0) ? 16'd0 : 16'($urandom_range(1024, 12000));
        ratio = ($urandom_range(5) == 0) ? 16'd0 : 16'($urandom_range(2048, 10000));
        load_view(pack3(rand_signed(12000), rand_signed(12000), rand_signed(12000)),
                  back, right, up, {16'(farv), 16'(nearv)}, tanv, ratio,
                  {16'($urandom_range(4096, 10000)), 16'($urandom_range(4096, 10000))});
    endtask

    // all registers still at their reset value of zero
    task automatic test_reset_values();
        idle_pct = 0;
        send_query(16'sd0, 16'sd0, 16'sd0, 15'd0);
        send_query(16'sd100, -16'sd100, 16'sd50, 15'd0);
        send_query(16'sd0, 16'sd0, 16'sd0, 15'd5);
        send_query(-16'sd32768, 16'sd32767, 16'sd0, 15'd32767);
        wait_drained();
    endtask

    // hand-placed spheres around the nominal view
    task automatic test_directed_geometry();
        idle_pct = 0;
        load_nominal_view();
        send_query(16'sd160, 16'sd320, -16'sd320, 15'd0);    // centered at depth 50
        send_query(16'sd160, 16'sd320, -16'sd1920, 15'd0);   // past far
        send_query(16'sd160, 16'sd320, 16'sd640, 15'd0);     // behind the eye
        send_query(16'sd160, 16'sd320, 16'sd480, 15'd0);     // at the eye
        send_query(16'sd160, 16'sd320, 16'sd464, 15'd0);     // on the near plane
        send_query(16'sd160, 16'sd320, -16'sd1120, 15'd0);   // on the far plane
        send_query(16'sd160, 16'sd320, -16'sd1120, 15'd32);  // straddles far
        send_query(16'sd160, 16'sd320, 16'sd464, 15'd8);     // straddles near
        send_query(16'sd1200, 16'sd320, -16'sd320, 15'd48);  // straddles right side
        send_query(16'sd1460, 16'sd320, -16'sd320, 15'd48);  // clear of right side
        send_query(-16'sd880, 16'sd320, -16'sd320, 15'd48);  // straddles left side
        send_query(16'sd160, 16'sd1110, -16'sd320, 15'd32);  // straddles top
        send_query(16'sd160, -16'sd580, -16'sd320, 15'd16);  // below bottom
        send_query(16'sd160, 16'sd320, -16'sd320, 15'd32767); // largest radius
        send_query(16'sd160, 16'sd320, -16'sd320, 15'd1);
        // coordinate extremes
        send_query(-16'sd32768, -16'sd32768, -16'sd32768, 15'd0);
        send_query(16'sd32767, 16'sd32767, 16'sd32767, 15'd32767);
        send_query(-16'sd32768, 16'sd32767, -16'sd32768, 15'd16383);
        send_query(16'sd32767, -16'sd32768, 16'sd32767, 15'd0);
        wait_drained();
    endtask

    // zero tangent, then zero ratio, then no widening: side bounds collapse
    task automatic test_zero_scale();
        idle_pct = 0;
        write_reg(CFG_TAN_HALF_FOV, 48'd0);
        send_query(16'sd160, 16'sd320, -16'sd320, 15'd0);
        send_query(16'sd161, 16'sd320, -16'sd320, 15'd0);
        send_query(16'sd160, 16'sd320, -16'sd320, 15'd16);
        send_query(16'sd160, 16'sd330, -16'sd320, 15'd0);
        wait_drained();
        write_reg(CFG_TAN_HALF_FOV, 48'd4096);
        write_reg(CFG_ASPECT_RATIO, 48'd0);
        send_query(16'sd160, 16'sd320, -16'sd320, 15'd0);
        send_query(16'sd170, 16'sd320, -16'sd320, 15'd0);
        send_query(16'sd160, 16'sd600, -16'sd320, 15'd0);
        wait_drained();
        write_reg(CFG_SPHERE_WIDEN, 48'd0);
        send_query(16'sd160, 16'sd320, -16'sd320, 15'd24);
        send_query(16'sd165, 16'sd320, -16'sd320, 15'd24);
        wait_drained();
    endtask

    // registers at their extremes, each with a batch of random spheres
    task automatic test_register_extremes();
        idle_pct = 0;
        load_view({48{1'b1}}, {48{1'b1}}, {48{1'b1}}, {48{1'b1}},
                  32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        repeat (30) send_random_item();
        wait_drained();
        load_view(pack3(-32768, -32768, -32768), pack3(-32768, -32768, -32768),
                  pack3(-32768, 0, 0), pack3(0, -32768, 0), 32'h0000_FFFF,
                  16'hFFFF, 16'd1, 32'd0);
        repeat (30) send_random_item();
        wait_drained();
        load_view(pack3(32767, 32767, 32767), pack3(0, 0, 16384), pack3(16384, 0, 0),
                  pack3(0, 16384, 0), 32'hFFFF_0000, 16'd1, 16'hFFFF, 32'hFFFF_0001);
        repeat (30) send_random_item();
        wait_drained();
        load_view('0, '0, '0, '0, '0, '0, '0, '0);
        repeat (20) send_random_item();
        wait_drained();
    endtask

    // back-to-back burst, full stop until empty, then another burst
    task automatic test_drain_pause();
        idle_pct = 0;
        load_nominal_view();
        repeat (25) send_framed();
        wait_drained();
        repeat (25) send_framed();
        wait_drained();
    endtask

    // random views under each idling pattern of the sender
    task automatic test_random_views();
        int phase_idle[4];
        phase_idle = '{0, 86, 0, 15};
        foreach (phase_idle[ph])
        begin
            repeat (2)
            begin
                idle_pct = 0;
                load_random_view();
                idle_pct = phase_idle[ph];
                repeat (200) send_random_item();
                wait_drained();
            end
        end
    endtask

    // verdict check: every done must match the oldest owed verdict
    always @(posedge clk)
    begin : verdict_check
        fspc_verdict_t due;
        if (rst_n && done === 1'b1)
        begin
            if (verdicts_due.size() == 0)
            begin
                $error("verdict with none owed: actual %0d", verdict);
                error_count++;
            end
            else
            begin
                due = verdicts_due.pop_front();
                if (verdict !== due)
                begin
                    $error("verdict mismatch: expected %0d actual %0d", due, verdict);
                    error_count++;
                end
            end
        end
    end

    // watchdog: too long without a request, a verdict or a register write
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        // every input known from time zero
        rst_n         = 1'b0;
        start         = 1'b0;
        point_x       = '0;
        point_y       = '0;
        point_z       = '0;
        sphere_radius = '0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_CAMERA_POSITION;
        cfg_data      = '0;
        // shadow registers follow the block's reset values
        cam_pos       = '0;
        axis_back     = '0;
        axis_right    = '0;
        axis_up       = '0;
        near_far      = '0;
        widen         = '0;
        tan_fov       = '0;
        aspect        = '0;
        error_count   = 0;
        idle_pct      = 0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_values();
        test_directed_geometry();
        test_zero_scale();
        test_register_extremes();
        test_drain_pause();
        test_random_views();

        // let the last verdicts land, then a short quiet tail
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0 && verdicts_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
